// ===== hw/rtl/prmv_pkg.sv =====
// Package for the pixel running mean / variance block.
// Field widths, status codes, state enums and lane control types.
// No dependencies.
package prmv_pkg;

  // Fixed field widths
  localparam int COORD_W  = 9;
  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 8;
  localparam int MEAN_W   = 16;
  localparam int VAR_W    = 31;
  localparam int SEEN_W   = 24;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 1;
  localparam int LIM_W    = 13;

  // Accumulator widths
  localparam int SUM_W = 40;
  localparam int SSQ_W = 56;

  // Parameter defaults
  localparam int DEF_MAX_ROWS   = 512;
  localparam int DEF_MAX_COLS   = 512;
  localparam int DEF_COUNT_BITS = 24;

  // Reset value of the active size registers
  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(512);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_CALC,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    LP_IDLE,
    LP_PROD,
    LP_SQW,
    LP_ACC,
    LP_MUL,
    LP_CMP,
    LP_DIV,
    LP_DONE
  } lane_phase_e;

  // Control from the sequencer to each channel lane
  typedef struct packed {
    logic start;
    logic apply;
  } lane_ctrl_t;

endpackage

// ===== hw/rtl/prmv_if.sv =====
// Stream interfaces of the pixel running mean / variance block.
// Input sample channel and result channel; depends on prmv_pkg.
interface prmv_in_if;
  import prmv_pkg::*;
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  pixel_row;
  logic [COORD_W-1:0]  pixel_col;
  logic [SAMPLE_W-1:0] sample_red;
  logic [SAMPLE_W-1:0] sample_green;
  logic [SAMPLE_W-1:0] sample_blue;
  logic [WEIGHT_W-1:0] weight;

  modport source (output valid, pixel_row, pixel_col, sample_red, sample_green,
                  sample_blue, weight, input ready);
  modport sink (input valid, pixel_row, pixel_col, sample_red, sample_green,
                sample_blue, weight, output ready);
endinterface

interface prmv_out_if;
  import prmv_pkg::*;
  logic                valid;
  logic                ready;
  logic [MEAN_W-1:0]   mean_red;
  logic [MEAN_W-1:0]   mean_green;
  logic [MEAN_W-1:0]   mean_blue;
  logic [VAR_W-1:0]    var_red;
  logic [VAR_W-1:0]    var_green;
  logic [VAR_W-1:0]    var_blue;
  logic [SEEN_W-1:0]   samples_seen;
  logic [STATUS_W-1:0] status;

  modport source (output valid, mean_red, mean_green, mean_blue, var_red, var_green,
                  var_blue, samples_seen, status, input ready);
  modport sink (input valid, mean_red, mean_green, mean_blue, var_red, var_green,
                var_blue, samples_seen, status, output ready);
endinterface

// ===== hw/rtl/prmv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/prmv_lane.sv =====
// One color channel lane: sum and sum-of-squares update, then mean and
// variance through shift-add multipliers and restoring dividers.
// Depends on prmv_pkg.
module prmv_lane #(
  parameter int COUNT_BITS = prmv_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  prmv_pkg::lane_ctrl_t           ctrl_i,
  input  logic [prmv_pkg::SAMPLE_W-1:0]  value_i,
  input  logic [prmv_pkg::WEIGHT_W-1:0]  weight_i,
  input  logic [COUNT_BITS-1:0]          count_i,
  input  logic [prmv_pkg::SUM_W-1:0]     sum_i,
  input  logic [prmv_pkg::SSQ_W-1:0]     sumsq_i,
  output logic                           done_o,
  output logic [prmv_pkg::SUM_W-1:0]     sum_o,
  output logic [prmv_pkg::SSQ_W-1:0]     sumsq_o,
  output logic [prmv_pkg::MEAN_W-1:0]    mean_o,
  output logic [prmv_pkg::VAR_W-1:0]     var_o
);
  import prmv_pkg::*;

  localparam int CB     = COUNT_BITS;
  localparam int NQ_W   = CB + SSQ_W;
  localparam int SS_W   = 2 * SUM_W;
  localparam int PROD_W = (NQ_W > SS_W) ? NQ_W : SS_W;
  localparam int DEN_W  = 2 * CB;
  localparam int CNT_W  = $clog2(PROD_W + 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(SUM_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

  lane_phase_e phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q;

  // Operand and update registers
  logic [SAMPLE_W-1:0]         v_q;
  logic [WEIGHT_W-1:0]         w_q;
  logic [CB-1:0]               n_q;
  logic                        apply_q;
  logic [2*SAMPLE_W-1:0]       vv_q;
  logic [SAMPLE_W+WEIGHT_W-1:0] vw_q;
  logic [2*SAMPLE_W+WEIGHT_W-1:0] vvw_q;
  logic [SUM_W-1:0]            s_q;
  logic [SSQ_W-1:0]            q_q;

  // Shift-add multipliers
  logic [PROD_W-1:0] ss_mc_q, ss_acc_q, nq_mc_q, nq_acc_q;
  logic [SUM_W-1:0]  ss_mr_q;
  logic [CB-1:0]     n_mr_q;
  logic [DEN_W-1:0]  nn_mc_q, nn_acc_q;

  // Mean divider
  logic [SUM_W-1:0]  md_num_q;
  logic [CB:0]       md_rem_q;
  logic [MEAN_W-1:0] md_quo_q;
  logic              md_sat_q;

  // Variance divider
  logic [PROD_W-1:0] vd_num_q;
  logic [DEN_W:0]    vd_rem_q;
  logic [31:0]       vd_quo_q;
  logic              vd_sat_q;
  logic              neg_q;

  logic [MEAN_W-1:0] mean_q;
  logic [VAR_W-1:0]  var_q;

  // Saturating accumulator updates
  logic [SUM_W:0] s_sum;
  logic [SSQ_W:0] q_sum;
  logic [SUM_W-1:0] s_nx;
  logic [SSQ_W-1:0] q_nx;
  always_comb begin
    s_sum = {1'b0, s_q} + (SUM_W + 1)'(vw_q);
    q_sum = {1'b0, q_q} + (SSQ_W + 1)'(vvw_q);
    if (!apply_q) begin
      s_nx = s_q;
      q_nx = q_q;
    end else begin
      s_nx = s_sum[SUM_W] ? {SUM_W{1'b1}} : s_sum[SUM_W-1:0];
      q_nx = q_sum[SSQ_W] ? {SSQ_W{1'b1}} : q_sum[SSQ_W-1:0];
    end
  end

  // Restoring division steps
  logic [CB:0]    md_try;
  logic [CB:0]    md_sub;
  logic           md_bit;
  logic [DEN_W:0] vd_try;
  logic [DEN_W:0] vd_sub;
  logic           vd_bit;
  always_comb begin
    md_try = {md_rem_q[CB-1:0], md_num_q[SUM_W-1]};
    md_bit = (md_try >= {1'b0, n_q});
    md_sub = md_bit ? (md_try - {1'b0, n_q}) : md_try;
    vd_try = {vd_rem_q[DEN_W-1:0], vd_num_q[PROD_W-1]};
    vd_bit = (vd_try >= {1'b0, nn_acc_q});
    vd_sub = vd_bit ? (vd_try - {1'b0, nn_acc_q}) : vd_try;
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      LP_IDLE: if (ctrl_i.start) phase_d = LP_PROD;
      LP_PROD: phase_d = LP_SQW;
      LP_SQW:  phase_d = LP_ACC;
      LP_ACC:  phase_d = LP_MUL;
      LP_MUL:  if (cnt_q == MUL_LAST) phase_d = LP_CMP;
      LP_CMP:  phase_d = LP_DIV;
      LP_DIV:  if (cnt_q == DIV_LAST) phase_d = LP_DONE;
      LP_DONE: phase_d = LP_IDLE;
      default: phase_d = LP_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done_o  = (phase_q == LP_DONE);
    sum_o   = s_q;
    sumsq_o = q_q;
    mean_o  = mean_q;
    var_o   = var_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= LP_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      if ((phase_q == LP_MUL && cnt_q == MUL_LAST) ||
          (phase_q == LP_DIV && cnt_q == DIV_LAST) || phase_q == LP_ACC) begin
        cnt_q <= '0;
      end else if (phase_q == LP_MUL || phase_q == LP_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      LP_IDLE: begin
        // Operands are held until the next start so write-back stays stable
        if (ctrl_i.start) begin
          v_q     <= value_i;
          w_q     <= weight_i;
          n_q     <= count_i;
          apply_q <= ctrl_i.apply;
          s_q     <= sum_i;
          q_q     <= sumsq_i;
        end
      end
      LP_PROD: begin
        vv_q <= v_q * v_q;
        vw_q <= v_q * w_q;
      end
      LP_SQW: vvw_q <= vv_q * w_q;
      LP_ACC: begin
        s_q      <= s_nx;
        q_q      <= q_nx;
        ss_mc_q  <= PROD_W'(s_nx);
        ss_mr_q  <= s_nx;
        ss_acc_q <= '0;
        nq_mc_q  <= PROD_W'(q_nx);
        nq_acc_q <= '0;
        n_mr_q   <= n_q;
        nn_mc_q  <= DEN_W'(n_q);
        nn_acc_q <= '0;
        md_num_q <= s_nx;
        md_rem_q <= '0;
        md_quo_q <= '0;
        md_sat_q <= 1'b0;
      end
      LP_MUL: begin
        // s*s, n*sumsq, n*n one multiplier bit a cycle; mean quotient alongside
        if (ss_mr_q[0]) ss_acc_q <= ss_acc_q + ss_mc_q;
        ss_mc_q <= ss_mc_q << 1;
        ss_mr_q <= ss_mr_q >> 1;
        if (n_mr_q[0]) begin
          nq_acc_q <= nq_acc_q + nq_mc_q;
          nn_acc_q <= nn_acc_q + nn_mc_q;
        end
        nq_mc_q  <= nq_mc_q << 1;
        nn_mc_q  <= nn_mc_q << 1;
        n_mr_q   <= n_mr_q >> 1;
        md_num_q <= md_num_q << 1;
        md_rem_q <= md_sub;
        md_sat_q <= md_sat_q | md_quo_q[MEAN_W-1];
        md_quo_q <= {md_quo_q[MEAN_W-2:0], md_bit};
      end
      LP_CMP: begin
        neg_q    <= (nq_acc_q < ss_acc_q);
        vd_num_q <= nq_acc_q - ss_acc_q;
        vd_rem_q <= '0;
        vd_quo_q <= '0;
        vd_sat_q <= 1'b0;
        mean_q   <= md_sat_q ? {MEAN_W{1'b1}} : md_quo_q;
      end
      LP_DIV: begin
        vd_num_q <= vd_num_q << 1;
        vd_rem_q <= vd_sub;
        vd_sat_q <= vd_sat_q | vd_quo_q[30];
        vd_quo_q <= {vd_quo_q[30:0], vd_bit};
      end
      LP_DONE: begin
        // Empty pixel and negative numerator read as zero
        if (n_q == '0) begin
          mean_q <= '0;
          var_q  <= '0;
        end else if (neg_q) begin
          var_q <= '0;
        end else if (vd_sat_q || vd_quo_q[31]) begin
          var_q <= {VAR_W{1'b1}};
        end else begin
          var_q <= vd_quo_q[VAR_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/pixel_running_mean_variance.sv =====
// Per-pixel running mean and population variance accumulator.
// Sequencer, pixel store, three channel lanes and the result merge.
// Depends on prmv_pkg, prmv_if, prmv_ram and prmv_lane.
//
// After reset the block runs a clearing pass over all MAX_ROWS*MAX_COLS
// addresses (262144 by default) of the pixel store, during which no
// transaction is accepted; configuration writes are taken at any time. The
// lanes use bit-serial multipliers (40 steps) and a restoring variance
// divider (P steps), P = max(COUNT_BITS + 56, 80); the three color channels
// run in parallel lanes. A finished result sits in an output register, so
// the next sample is taken while it waits. Out-of-range coordinates skip
// the lanes and return status 1.
module pixel_running_mean_variance #(
  parameter int MAX_ROWS   = prmv_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = prmv_pkg::DEF_MAX_COLS,
  parameter int COUNT_BITS = prmv_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [prmv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [prmv_pkg::CFG_W-1:0]     cfg_data_i,
  prmv_in_if.sink                        in_i,
  prmv_out_if.source                     out_o
);
  import prmv_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB     = COUNT_BITS;
  localparam int WORD_W = 3 * SUM_W + 3 * SSQ_W + CB;
  localparam int SQ_OFS = 3 * SUM_W;
  localparam int N_OFS  = 3 * SUM_W + 3 * SSQ_W;
  localparam int NLANE  = 3;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [LIM_W-1:0]  ROW_MAX = LIM_W'(MAX_ROWS);
  localparam logic [LIM_W-1:0]  COL_MAX = LIM_W'(MAX_COLS);

  ctrl_state_e state_q, state_d;

  // Configuration registers
  logic [CFG_W-1:0] width_q, height_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_RESET;
      height_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTIVE_WIDTH:  width_q  <= cfg_data_i;
        CFG_ACTIVE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Range check and address of the incoming transaction
  logic [LIM_W-1:0] cols_eff, rows_eff;
  logic             in_range;
  logic [ADDR_W-1:0] in_addr;
  always_comb begin
    cols_eff = (LIM_W'(width_q) > COL_MAX) ? COL_MAX : LIM_W'(width_q);
    rows_eff = (LIM_W'(height_q) > ROW_MAX) ? ROW_MAX : LIM_W'(height_q);
    in_range = (LIM_W'(in_i.pixel_row) < rows_eff) &&
               (LIM_W'(in_i.pixel_col) < cols_eff);
    in_addr  = ADDR_W'(int'(in_i.pixel_row) * MAX_COLS + int'(in_i.pixel_col));
  end

  logic in_ready, in_fire;
  assign in_ready   = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Captured transaction
  logic [ADDR_W-1:0]   addr_q;
  logic                range_err_q;
  logic [SAMPLE_W-1:0] val_q [NLANE];
  logic [WEIGHT_W-1:0] w_q;
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      addr_q      <= in_addr;
      range_err_q <= !in_range;
      val_q[0]    <= in_i.sample_red;
      val_q[1]    <= in_i.sample_green;
      val_q[2]    <= in_i.sample_blue;
      w_q         <= in_i.weight;
    end
  end

  // Pixel store and clearing pass
  logic [ADDR_W-1:0] clr_addr_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;
  logic [WORD_W-1:0] wb_word;

  prmv_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(addr_q),
    .rdata_o(mem_rdata)
  );

  // Overflow check on the stored count
  logic [CB-1:0] old_n;
  logic [CB:0]   n_sum;
  logic          ovf;
  assign old_n = mem_rdata[N_OFS +: CB];
  assign n_sum = {1'b0, old_n} + (CB + 1)'(w_q);
  assign ovf   = n_sum[CB];

  logic [CB-1:0] n_q;
  logic          apply_q;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      n_q     <= ovf ? old_n : n_sum[CB-1:0];
      apply_q <= !ovf;
    end
  end

  // Channel lanes
  lane_ctrl_t        lane_ctrl;
  logic [NLANE-1:0]  lane_done;
  logic [SUM_W-1:0]  lane_sum [NLANE];
  logic [SSQ_W-1:0]  lane_sq  [NLANE];
  logic [MEAN_W-1:0] lane_mean [NLANE];
  logic [VAR_W-1:0]  lane_var  [NLANE];

  assign lane_ctrl.start = (state_q == ST_LOAD) && !range_err_q;
  assign lane_ctrl.apply = !ovf;

  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    prmv_lane #(.COUNT_BITS(CB)) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .value_i (val_q[g]),
      .weight_i(w_q),
      .count_i (ovf ? old_n : n_sum[CB-1:0]),
      .sum_i   (mem_rdata[g*SUM_W +: SUM_W]),
      .sumsq_i (mem_rdata[SQ_OFS + g*SSQ_W +: SSQ_W]),
      .done_o  (lane_done[g]),
      .sum_o   (lane_sum[g]),
      .sumsq_o (lane_sq[g]),
      .mean_o  (lane_mean[g]),
      .var_o   (lane_var[g])
    );
    assign wb_word[g*SUM_W +: SUM_W]          = lane_sum[g];
    assign wb_word[SQ_OFS + g*SSQ_W +: SSQ_W] = lane_sq[g];
  end
  assign wb_word[N_OFS +: CB] = n_q;

  // Output register
  logic out_valid_q, out_free;
  assign out_free = !out_valid_q || out_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_addr_q == LAST_ADDR) state_d = ST_IDLE;
      ST_IDLE:  if (in_fire) state_d = ST_READ;
      ST_READ:  state_d = range_err_q ? ST_DONE : ST_LOAD;
      ST_LOAD:  state_d = ST_CALC;
      ST_CALC:  if (lane_done[0]) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Store write: clearing pass or write-back of an applied update
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = wb_word;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = '0;
      end
      ST_DONE: mem_we = !range_err_q && apply_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Merge the lanes into one result transaction
  logic [MEAN_W-1:0]   mean_q [NLANE];
  logic [VAR_W-1:0]    var_q  [NLANE];
  logic [SEEN_W-1:0]   seen_q;
  logic [STATUS_W-1:0] status_q;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      for (int i = 0; i < NLANE; i++) begin
        mean_q[i] <= range_err_q ? '0 : lane_mean[i];
        var_q[i]  <= range_err_q ? '0 : lane_var[i];
      end
      seen_q <= range_err_q ? '0 : SEEN_W'(n_q);
      if (range_err_q)   status_q <= STATUS_RANGE;
      else if (!apply_q) status_q <= STATUS_OVERFLOW;
      else               status_q <= STATUS_OK;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.mean_red     = mean_q[0];
  assign out_o.mean_green   = mean_q[1];
  assign out_o.mean_blue    = mean_q[2];
  assign out_o.var_red      = var_q[0];
  assign out_o.var_green    = var_q[1];
  assign out_o.var_blue     = var_q[2];
  assign out_o.samples_seen = seen_q;
  assign out_o.status       = status_q;

`ifndef SYNTHESIS
  // Lanes run in lockstep
  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_done == '0) || (lane_done == {NLANE{1'b1}}))
    else $error("channel lanes out of step");

  // No transaction taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_i.ready)
    else $error("input ready during clearing pass");

  // Range errors never touch the store
  a_range_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR && range_err_q) |-> !mem_we)
    else $error("store written for out-of-range pixel");

  // A range error result carries zero count
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == STATUS_RANGE) |-> (out_o.samples_seen == '0))
    else $error("range error result with nonzero count");
`endif

endmodule

// ===== bench/tb_pixel_running_mean_variance.sv =====
// Self-checking bench for the pixel running mean / variance accumulator.
// Directed table then random samples, checked against a per-pixel predictor.
// Depends on prmv_pkg, prmv_if and the pixel_running_mean_variance RTL.
`timescale 1ns / 100ps

module tb_pixel_running_mean_variance;
  import prmv_pkg::*;

  localparam int ROWS_MAX   = DEF_MAX_ROWS;
  localparam int COLS_MAX   = DEF_MAX_COLS;
  localparam int WATCHDOG   = 1200000;  // covers the clearing pass after reset
  localparam int DRAIN_CYC  = 300;
  localparam int N_RANDOM   = 680;
  localparam int HOLD_CYC   = 2000;

  typedef struct packed {
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [SAMPLE_W-1:0] r;
    logic [SAMPLE_W-1:0] g;
    logic [SAMPLE_W-1:0] b;
    logic [WEIGHT_W-1:0] w;
  } sample_t;

  typedef struct packed {
    logic [MEAN_W-1:0]   mean_r;
    logic [MEAN_W-1:0]   mean_g;
    logic [MEAN_W-1:0]   mean_b;
    logic [VAR_W-1:0]    var_r;
    logic [VAR_W-1:0]    var_g;
    logic [VAR_W-1:0]    var_b;
    logic [SEEN_W-1:0]   seen;
    logic [STATUS_W-1:0] status;
  } stats_t;

  typedef struct {
    logic [SUM_W-1:0]  sum[3];
    logic [SSQ_W-1:0]  ssq[3];
    logic [SEEN_W-1:0] cnt;
  } pixel_acc_t;

  // One table row: optional size change first, optional typed expectation
  typedef struct {
    bit          set_size;
    logic [9:0]  width;
    logic [9:0]  height;
    sample_t     smp;
    bit          typed;
    stats_t      res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_ACTIVE_WIDTH;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  prmv_in_if  in_if ();
  prmv_out_if out_if ();

  pixel_running_mean_variance u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state
  pixel_acc_t pixel_db[int];
  logic [CFG_W-1:0] act_width = SIZE_RESET;
  logic [CFG_W-1:0] act_height = SIZE_RESET;
  stats_t expected_q[$];

  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int range_hits = 0;
  int size_settings = 0;
  int snd_pct = 28;
  int rcv_pct = 52;
  int hold_cnt = 0;
  int idle_cnt = 0;

  initial begin
    in_if.valid        = 1'b0;
    in_if.pixel_row    = '0;
    in_if.pixel_col    = '0;
    in_if.sample_red   = '0;
    in_if.sample_green = '0;
    in_if.sample_blue  = '0;
    in_if.weight       = '0;
    out_if.ready       = 1'b0;
  end

  // Mean and population variance of one channel, truncated and saturated
  function automatic void channel_stats(input logic [SUM_W-1:0] s, input logic [SSQ_W-1:0] q,
                                        input logic [SEEN_W-1:0] n,
                                        output logic [MEAN_W-1:0] mean,
                                        output logic [VAR_W-1:0] vr);
    logic [127:0] nq, ss, nn, quo, m;
    if (n == 0) begin
      mean = '0;
      vr = '0;
      return;
    end
    m = 128'(s) / 128'(n);
    mean = (m > 128'hFFFF) ? 16'hFFFF : m[MEAN_W-1:0];
    nq = 128'(n) * 128'(q);
    ss = 128'(s) * 128'(s);
    nn = 128'(n) * 128'(n);
    if (nq < ss) begin
      vr = '0;
    end else begin
      quo = (nq - ss) / nn;
      vr = (quo > 128'h7FFF_FFFF) ? 31'h7FFF_FFFF : quo[VAR_W-1:0];
    end
  endfunction

  // Apply one sample to the pixel store and return its statistics
  function automatic stats_t accumulate(input sample_t it);
    stats_t res;
    pixel_acc_t px;
    int cols, rows, key;
    logic [SAMPLE_W-1:0] v[3];
    logic [24:0] n_next;
    logic [63:0] t;
    res = '0;
    cols = (act_width > COLS_MAX) ? COLS_MAX : act_width;
    rows = (act_height > ROWS_MAX) ? ROWS_MAX : act_height;
    if (it.row >= rows || it.col >= cols) begin
      res.status = STATUS_RANGE;
      return res;
    end
    key = it.row * COLS_MAX + it.col;
    if (pixel_db.exists(key)) begin
      px = pixel_db[key];
    end else begin
      for (int c = 0; c < 3; c++) begin
        px.sum[c] = '0;
        px.ssq[c] = '0;
      end
      px.cnt = '0;
    end
    v[0] = it.r;
    v[1] = it.g;
    v[2] = it.b;
    n_next = 25'(px.cnt) + 25'(it.w);
    if (n_next > 25'hFF_FFFF) begin
      res.status = STATUS_OVERFLOW;
    end else begin
      res.status = STATUS_OK;
      px.cnt = n_next[SEEN_W-1:0];
      for (int c = 0; c < 3; c++) begin
        t = 64'(px.sum[c]) + 64'(v[c]) * 64'(it.w);
        px.sum[c] = (t > 64'hFF_FFFF_FFFF) ? '1 : t[SUM_W-1:0];
        t = 64'(px.ssq[c]) + 64'(v[c]) * 64'(v[c]) * 64'(it.w);
        px.ssq[c] = (t > 64'hFF_FFFF_FFFF_FFFF) ? '1 : t[SSQ_W-1:0];
      end
      pixel_db[key] = px;
    end
    channel_stats(px.sum[0], px.ssq[0], px.cnt, res.mean_r, res.var_r);
    channel_stats(px.sum[1], px.ssq[1], px.cnt, res.mean_g, res.var_g);
    channel_stats(px.sum[2], px.ssq[2], px.cnt, res.mean_b, res.var_b);
    res.seen = px.cnt;
    return res;
  endfunction

  // Offer one sample; on acceptance queue its expected statistics
  task automatic send_sample(input sample_t it, input bit typed, input stats_t typed_res);
    stats_t pred;
    if (snd_pct > 0 && $urandom_range(99) < snd_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_pct);
    end
    in_if.valid        <= 1'b1;
    in_if.pixel_row    <= it.row;
    in_if.pixel_col    <= it.col;
    in_if.sample_red   <= it.r;
    in_if.sample_green <= it.g;
    in_if.sample_blue  <= it.b;
    in_if.weight       <= it.w;
    do @(posedge clk_i); while (!in_if.ready);
    pred = accumulate(it);
    if (pred.status == STATUS_RANGE) range_hits++;
    expected_q.push_back(typed ? typed_res : pred);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain;
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  task automatic write_size(input logic [9:0] w, input logic [9:0] h);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ACTIVE_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ACTIVE_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    act_width  = w;
    act_height = h;
    size_settings++;
  endtask

  // Result check, receiver idling and watchdog
  always @(posedge clk_i) begin
    stats_t got, exp_r;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= WATCHDOG) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG);
      $display("RESULT: ERROR");
      $finish;
    end
    if (out_if.valid && out_if.ready) begin
      got = '{out_if.mean_red, out_if.mean_green, out_if.mean_blue, out_if.var_red,
              out_if.var_green, out_if.var_blue, out_if.samples_seen, out_if.status};
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got.mean_r !== exp_r.mean_r || got.mean_g !== exp_r.mean_g ||
            got.mean_b !== exp_r.mean_b || got.var_r !== exp_r.var_r ||
            got.var_g !== exp_r.var_g || got.var_b !== exp_r.var_b ||
            got.seen !== exp_r.seen || got.status !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at result %0d", results_seen);
            $display("  expected %p", exp_r);
            $display("  actual   %p", got);
          end
        end
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(rcv_pct > 0 && $urandom_range(99) < rcv_pct);
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_value;
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  dir_row_t dir_tab[$];

  initial begin
    sample_t it;
    stats_t zero_res;
    logic [9:0] w, h;
    zero_res = '0;

    // Fresh pixels and out-of-range rows carry typed results
    dir_tab = '{
      '{0, 0, 0, '{9'd0, 9'd0, 16'h0, 16'h0, 16'h0, 8'd0}, 1, zero_res},
      '{0, 0, 0, '{9'd0, 9'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255}, 1,
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 31'd0, 31'd0, 31'd0, 24'd255, STATUS_OK}},
      '{0, 0, 0, '{9'd511, 9'd511, 16'h1000, 16'h0, 16'hFFFF, 8'd1}, 1,
        '{16'h1000, 16'h0, 16'hFFFF, 31'd0, 31'd0, 31'd0, 24'd1, STATUS_OK}},
      '{0, 0, 0, '{9'd511, 9'd511, 16'h3000, 16'h8000, 16'h0, 8'd1}, 0, zero_res},
      '{0, 0, 0, '{9'd511, 9'd511, 16'h1234, 16'h5678, 16'h9ABC, 8'd0}, 0, zero_res},
      '{0, 0, 0, '{9'd0, 9'd0, 16'h0, 16'h0, 16'h0, 8'd255}, 0, zero_res},
      '{0, 0, 0, '{9'd0, 9'd0, 16'hFFFF, 16'h0, 16'h8000, 8'd128}, 0, zero_res},
      '{1, 10'd1, 10'd1, '{9'd0, 9'd1, 16'h1111, 16'h2222, 16'h3333, 8'd5}, 1,
        '{16'h0, 16'h0, 16'h0, 31'd0, 31'd0, 31'd0, 24'd0, STATUS_RANGE}},
      '{0, 0, 0, '{9'd1, 9'd0, 16'h1111, 16'h2222, 16'h3333, 8'd5}, 1,
        '{16'h0, 16'h0, 16'h0, 31'd0, 31'd0, 31'd0, 24'd0, STATUS_RANGE}},
      '{0, 0, 0, '{9'd0, 9'd0, 16'h4000, 16'h2000, 16'h1000, 8'd7}, 0, zero_res},
      '{1, 10'd0, 10'd512, '{9'd0, 9'd0, 16'h4000, 16'h2000, 16'h1000, 8'd7}, 1,
        '{16'h0, 16'h0, 16'h0, 31'd0, 31'd0, 31'd0, 24'd0, STATUS_RANGE}},
      '{1, 10'd512, 10'd0, '{9'd0, 9'd0, 16'h4000, 16'h2000, 16'h1000, 8'd7}, 1,
        '{16'h0, 16'h0, 16'h0, 31'd0, 31'd0, 31'd0, 24'd0, STATUS_RANGE}},
      '{1, 10'd1023, 10'd1023, '{9'd511, 9'd511, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255},
        0, zero_res},
      '{0, 0, 0, '{9'd511, 9'd0, 16'hAAAA, 16'h5555, 16'h0001, 8'd200}, 0, zero_res},
      '{0, 0, 0, '{9'd256, 9'd255, 16'h8000, 16'h7FFF, 16'h00FF, 8'd1}, 0, zero_res}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    size_settings = 1;

    // Directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_size) write_size(dir_tab[i].width, dir_tab[i].height);
      send_sample(dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].res);
    end

    // Random samples, mostly folded onto a few pixels so their statistics grow
    write_size(10'd512, 10'd512);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        snd_pct = 52;
        rcv_pct = 28;
      end else if (n == 2 * N_RANDOM / 3) begin
        snd_pct = 0;
        rcv_pct = 0;
      end
      if (n % 120 == 119) begin
        case ($urandom_range(4))
          0:       begin w = 10'd1;    h = 10'd1;    end
          1:       begin w = 10'd1023; h = 10'd1023; end
          2:       begin w = 10'd4;    h = 10'd600;  end
          3:       begin w = 10'(1 + $urandom_range(1022)); h = 10'(1 + $urandom_range(1022)); end
          default: begin w = 10'd512;  h = 10'd512;  end
        endcase
        write_size(w, h);
      end
      if (n == 100) hold_cnt = HOLD_CYC;
      if (n == 200) drain();
      if ($urandom_range(9) < 7) begin
        it.row = COORD_W'($urandom_range(3));
        it.col = COORD_W'($urandom_range(3));
      end else begin
        it.row = COORD_W'($urandom);
        it.col = COORD_W'($urandom);
      end
      it.r = rand_value();
      it.g = rand_value();
      it.b = rand_value();
      case ($urandom_range(7))
        0:       it.w = '0;
        1:       it.w = '1;
        default: it.w = WEIGHT_W'($urandom);
      endcase
      send_sample(it, 1'b0, zero_res);
    end

    drain();
    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("covered %0d samples, %0d results, %0d out-of-range, %0d size settings",
             items_sent, results_seen, range_hits, size_settings);
    $display("pixels touched: %0d, mismatches: %0d", pixel_db.num(), mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== pixel_running_mean_variance.f =====
hw/rtl/prmv_pkg.sv
hw/rtl/prmv_if.sv
hw/rtl/prmv_ram.sv
hw/rtl/prmv_lane.sv
hw/rtl/pixel_running_mean_variance.sv
bench/tb_pixel_running_mean_variance.sv
